// File: design/mcct_pkg.sv
`default_nettype none
package mcct_pkg;

    typedef enum logic [2:0] {
        KIND_UPPER     = 3'd0,
        KIND_LOWER     = 3'd1,
        KIND_PLAIN     = 3'd2,
        KIND_CAP_WORDS = 3'd3,
        KIND_CAP_FIRST = 3'd4
    } kind_t;

    typedef struct packed {
        logic eligible;
        logic finished;
    } word_ctx_t;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_APOS = 8'h27;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_C = 8'h63;
    localparam logic [7:0] CH_E = 8'h65;
    localparam logic [7:0] CH_I = 8'h69;
    localparam logic [7:0] CH_N = 8'h6E;
    localparam logic [7:0] CH_O = 8'h6F;
    localparam logic [7:0] CH_U = 8'h75;
    localparam logic [7:0] CH_Y = 8'h79;
    localparam logic [7:0] CASE_OFS = 8'h20;

    function automatic logic [7:0] to_upper(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if ((b >= 8'h61 && b <= 8'h7A) || b >= 8'hE0)
        begin
            r = b - CASE_OFS;
        end
        else if (b == 8'hB8)
        begin
            r = 8'hA8;
        end
        else
        begin
            case (b)
                8'd129: r = 8'd154;
                8'd164: r = 8'd165;
                8'd132: r = 8'd142;
                8'd134: r = 8'd143;
                8'd130: r = 8'd144;
                8'd148: r = 8'd153;
                8'd135: r = 8'd128;
                8'd145: r = 8'd146;
                default: r = b;
            endcase
        end
        return r;
    endfunction

    function automatic logic [7:0] lower_letters(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'hC0 && b <= 8'hDF))
        begin
            r = b + CASE_OFS;
        end
        else if (b == 8'hA8)
        begin
            r = 8'hB8;
        end
        return r;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        logic [7:0] l;
        logic [7:0] r;
        l = lower_letters(b);
        case (l)
            8'd154: r = 8'd129;
            8'd165: r = 8'd164;
            8'd142: r = 8'd132;
            8'd143: r = 8'd134;
            8'd144: r = 8'd130;
            8'd153: r = 8'd148;
            8'd128: r = 8'd135;
            8'd146: r = 8'd145;
            default: r = l;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] to_plain(input logic [7:0] b);
        logic [7:0] l;
        logic [7:0] r;
        l = lower_letters(b);
        case (l)
            8'd129, 8'd150, 8'd151, 8'd154, 8'd163: r = CH_U;
            8'd152: r = CH_Y;
            8'd164, 8'd165: r = CH_N;
            8'd131, 8'd132, 8'd133, 8'd134, 8'd142, 8'd143,
            8'd145, 8'd146, 8'd160: r = CH_A;
            8'd130, 8'd136, 8'd137, 8'd138, 8'd144: r = CH_E;
            8'd139, 8'd140, 8'd141, 8'd161: r = CH_I;
            8'd147, 8'd148, 8'd149, 8'd153, 8'd162: r = CH_O;
            8'd128, 8'd135: r = CH_C;
            default: r = l;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: design/mcct_word_ctx.sv
`default_nettype none
module mcct_word_ctx (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic [2:0]        kind,
    input  wire logic [7:0]        char_in,
    input  wire logic              first_of_string,
    output mcct_pkg::word_ctx_t    ctx
);
    import mcct_pkg::*;

    logic [7:0] prev_reg;
    logic [7:0] prev2_reg;
    logic [1:0] pos_reg;
    logic       fin_reg;
    logic [1:0] pos;
    logic       fin;
    logic       eligible;
    logic       fin_set;
    logic [1:0] pos_next;

    always_comb
    begin
        pos = first_of_string ? 2'd0 : pos_reg;
        fin = first_of_string ? 1'b0 : fin_reg;
        if (pos == 2'd0)
        begin
            eligible = 1'b1;
        end
        else
        begin
            eligible = (prev_reg == CH_SPACE) || (prev_reg == CH_DQUOTE);
            if (prev_reg == CH_APOS &&
                (pos == 2'd1 || prev2_reg == CH_SPACE || prev2_reg == CH_COMMA))
            begin
                eligible = 1'b1;
            end
        end
        fin_set = (kind_t'(kind) == KIND_CAP_FIRST) && !fin && eligible &&
                  (char_in != CH_SPACE) && (char_in != CH_DQUOTE);
        pos_next = (pos >= 2'd2) ? 2'd2 : pos + 2'd1;
        ctx.eligible = eligible;
        ctx.finished = fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            prev2_reg <= '0;
            pos_reg   <= '0;
            fin_reg   <= 1'b0;
        end
        else if (advance)
        begin
            prev2_reg <= prev_reg;
            prev_reg  <= char_in;
            pos_reg   <= pos_next;
            fin_reg   <= fin | fin_set;
        end
    end

    // hold the word position within its saturation bound
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg != 2'd3)
        else $error("word position out of range");

    // advance shifts the byte history
    a_history: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (prev2_reg == $past(prev_reg)) && (prev_reg == $past(char_in)))
        else $error("byte history not shifted");

    // finished flag only rises through a capitalise-first beat
    a_fin_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(fin_reg) |-> $past(advance && kind_t'(kind) == KIND_CAP_FIRST))
        else $error("finished flag set outside its mode");

endmodule
`default_nettype wire

// File: design/mcct_char_map.sv
`default_nettype none
module mcct_char_map (
    input  wire logic [2:0]         kind,
    input  wire logic [7:0]         char_in,
    input  wire mcct_pkg::word_ctx_t ctx,
    output logic [7:0]              char_out
);
    import mcct_pkg::*;

    always_comb
    begin
        case (kind_t'(kind))
            KIND_UPPER:     char_out = to_upper(char_in);
            KIND_LOWER:     char_out = to_lower(char_in);
            KIND_PLAIN:     char_out = to_plain(char_in);
            KIND_CAP_WORDS: char_out = ctx.eligible ? to_upper(char_in) : char_in;
            KIND_CAP_FIRST: char_out = (ctx.eligible && !ctx.finished) ?
                                       to_upper(char_in) : char_in;
            default:        char_out = char_in;
        endcase
    end

endmodule
`default_nettype wire

// File: design/mixed_charset_case_transform.sv
// Pipeline: input register, then result register.
// Throughput: one byte per cycle while the result is not stalled; the word context updates as each beat enters
// the result register.
// Reset: asynchronous, active low; clears both valid flags and the word context,
// so the first byte after reset starts a string.
`default_nettype none
module mixed_charset_case_transform (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [2:0] kind,
    input  wire logic [7:0] char_in,
    input  wire logic       first_of_string,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      char_out
);
    import mcct_pkg::*;

    logic       s1_valid_reg;
    logic [2:0] s1_kind_reg;
    logic [7:0] s1_char_reg;
    logic       s1_first_reg;
    logic       out_valid_reg;
    logic [7:0] out_char_reg;
    logic       out_free;
    logic       s1_adv;
    logic       in_take;
    logic [7:0] out_char_next;
    word_ctx_t  ctx;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    mcct_word_ctx u_ctx (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (s1_adv),
        .kind            (s1_kind_reg),
        .char_in         (s1_char_reg),
        .first_of_string (s1_first_reg),
        .ctx             (ctx)
    );

    mcct_char_map u_map (
        .kind     (s1_kind_reg),
        .char_in  (s1_char_reg),
        .ctx      (ctx),
        .char_out (out_char_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take || s1_adv)
            begin
                s1_valid_reg <= in_take;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_kind_reg  <= kind;
            s1_char_reg  <= char_in;
            s1_first_reg <= first_of_string;
        end
        if (s1_adv)
        begin
            out_char_reg <= out_char_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign char_out  = out_char_reg;

    // stall only while a beat waits behind a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled without a blocked beat");

    // a beat leaving the input register lands in the result register
    a_adv_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg && (out_char_reg == $past(out_char_next)))
        else $error("advanced beat lost");

    // hold the waiting input beat while blocked
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> s1_valid_reg && $stable(s1_char_reg)
                                      && $stable(s1_kind_reg))
        else $error("waiting beat changed");

endmodule
`default_nettype wire

// File: verif/mixed_charset_case_transform_tb.sv
`default_nettype none
module mixed_charset_case_transform_tb;
    import mcct_pkg::*;

    localparam int CLK_HALF = 10;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_BEATS = 1200;
    localparam int CALM_TAIL = 150;
    localparam int LONG_HOLD = 80;
    localparam int HOLD_AT_BEAT = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int REPORT_LIMIT = 10;
    localparam logic [2:0] KIND_SPARE_5 = 3'd5;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [2:0] kind;
        logic       first;
        logic [7:0] ch;
    } beat_t;

    localparam beat_t DIRECTED [0:23] = '{
        '{KIND_UPPER,     1'b0, 8'h61},
        '{KIND_UPPER,     1'b0, 8'hFF},
        '{KIND_UPPER,     1'b0, 8'hB8},
        '{KIND_UPPER,     1'b0, 8'd135},
        '{KIND_LOWER,     1'b1, 8'h5A},
        '{KIND_LOWER,     1'b0, 8'hC0},
        '{KIND_LOWER,     1'b0, 8'hA8},
        '{KIND_LOWER,     1'b0, 8'd146},
        '{KIND_PLAIN,     1'b1, 8'hDF},
        '{KIND_PLAIN,     1'b0, 8'd152},
        '{KIND_PLAIN,     1'b0, 8'd165},
        '{KIND_PLAIN,     1'b0, 8'h00},
        '{KIND_CAP_WORDS, 1'b1, CH_APOS},
        '{KIND_CAP_WORDS, 1'b0, 8'h61},
        '{KIND_CAP_WORDS, 1'b0, CH_COMMA},
        '{KIND_CAP_WORDS, 1'b0, CH_APOS},
        '{KIND_CAP_WORDS, 1'b0, 8'h62},
        '{KIND_CAP_FIRST, 1'b1, CH_SPACE},
        '{KIND_CAP_FIRST, 1'b0, CH_DQUOTE},
        '{KIND_CAP_FIRST, 1'b0, 8'h78},
        '{KIND_CAP_FIRST, 1'b0, CH_SPACE},
        '{KIND_CAP_FIRST, 1'b0, 8'h79},
        '{KIND_SPARE_5,   1'b1, 8'h71},
        '{KIND_SPARE_7,   1'b0, 8'hFF}
    };

    class case_scoreboard;
        logic [7:0] prev_ch;
        logic [7:0] prev2_ch;
        logic [1:0] seen;
        bit         first_word_done;
        logic [7:0] expected_chars[$];
        int         beats_in;
        int         results_checked;
        int         mismatches;
        int         beats_per_kind[8];

        function new();
            prev_ch = 8'h00;
            prev2_ch = 8'h00;
            seen = 2'd0;
            first_word_done = 1'b0;
            beats_in = 0;
            results_checked = 0;
            mismatches = 0;
            foreach (beats_per_kind[i])
                beats_per_kind[i] = 0;
        endfunction

        function logic [7:0] raise_case(input logic [7:0] b);
            logic [7:0] r;
            r = b;
            if ((b >= 8'h61 && b <= 8'h7A) || b >= 8'hE0)
            begin
                r = b - CASE_OFS;
            end
            else if (b == 8'hB8)
            begin
                r = 8'hA8;
            end
            else
            begin
                case (b)
                    8'd129: r = 8'd154;
                    8'd164: r = 8'd165;
                    8'd132: r = 8'd142;
                    8'd134: r = 8'd143;
                    8'd130: r = 8'd144;
                    8'd148: r = 8'd153;
                    8'd135: r = 8'd128;
                    8'd145: r = 8'd146;
                    default: r = b;
                endcase
            end
            return r;
        endfunction

        function logic [7:0] letter_down(input logic [7:0] b);
            if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'hC0 && b <= 8'hDF))
            begin
                return b + CASE_OFS;
            end
            if (b == 8'hA8)
            begin
                return 8'hB8;
            end
            return b;
        endfunction

        function logic [7:0] drop_case(input logic [7:0] b);
            logic [7:0] l;
            l = letter_down(b);
            case (l)
                8'd154: return 8'd129;
                8'd165: return 8'd164;
                8'd142: return 8'd132;
                8'd143: return 8'd134;
                8'd144: return 8'd130;
                8'd153: return 8'd148;
                8'd128: return 8'd135;
                8'd146: return 8'd145;
                default: return l;
            endcase
        endfunction

        function logic [7:0] fold_plain(input logic [7:0] b);
            logic [7:0] l;
            l = letter_down(b);
            case (l)
                8'd129, 8'd150, 8'd151, 8'd154, 8'd163: return CH_U;
                8'd152: return CH_Y;
                8'd164, 8'd165: return CH_N;
                8'd131, 8'd132, 8'd133, 8'd134, 8'd142, 8'd143,
                8'd145, 8'd146, 8'd160: return CH_A;
                8'd130, 8'd136, 8'd137, 8'd138, 8'd144: return CH_E;
                8'd139, 8'd140, 8'd141, 8'd161: return CH_I;
                8'd147, 8'd148, 8'd149, 8'd153, 8'd162: return CH_O;
                8'd128, 8'd135: return CH_C;
                default: return l;
            endcase
        endfunction

        function void note_input(input logic [2:0] k, input logic [7:0] c, input logic f);
            logic [1:0] pos;
            bit         eligible;
            logic [7:0] r;
            if (f)
            begin
                seen = 2'd0;
                first_word_done = 1'b0;
            end
            pos = seen;
            if (pos == 2'd0)
            begin
                eligible = 1'b1;
            end
            else
            begin
                eligible = (prev_ch == CH_SPACE || prev_ch == CH_DQUOTE);
                if (prev_ch == CH_APOS &&
                    (pos == 2'd1 || prev2_ch == CH_SPACE || prev2_ch == CH_COMMA))
                begin
                    eligible = 1'b1;
                end
            end
            r = c;
            case (k)
                KIND_UPPER: r = raise_case(c);
                KIND_LOWER: r = drop_case(c);
                KIND_PLAIN: r = fold_plain(c);
                KIND_CAP_WORDS:
                begin
                    if (eligible)
                        r = raise_case(c);
                end
                KIND_CAP_FIRST:
                begin
                    if (!first_word_done && eligible)
                    begin
                        r = raise_case(c);
                        if (c != CH_SPACE && c != CH_DQUOTE)
                            first_word_done = 1'b1;
                    end
                end
                default: r = c;
            endcase
            prev2_ch = prev_ch;
            prev_ch = c;
            seen = (pos >= 2'd2) ? 2'd2 : pos + 2'd1;
            expected_chars.push_back(r);
            beats_in++;
            beats_per_kind[k]++;
        endfunction

        function void check_output(input logic [7:0] got);
            logic [7:0] want;
            if (expected_chars.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR: unexpected result beat char_out=%02h", got);
                return;
            end
            want = expected_chars.pop_front();
            results_checked++;
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR: result %0d char_out expected %02h actual %02h",
                             results_checked, want, got);
            end
        endfunction

        function int failures();
            return mismatches + expected_chars.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [2:0] kind = KIND_UPPER;
    logic [7:0] char_in = 8'h00;
    logic       first_of_string = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] char_out;

    case_scoreboard sb = new();
    bit calm = 1'b0;
    bit long_hold_done = 1'b0;
    int hold_left = 0;
    int idle_cycles = 0;
    int strings_sent = 0;

    mixed_charset_case_transform u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .char_in         (char_in),
        .first_of_string (first_of_string),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .char_out        (char_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 9))
            0: return CH_SPACE;
            1: return CH_DQUOTE;
            2: return CH_APOS;
            3: return CH_COMMA;
            4: return 8'($urandom_range(8'h61, 8'h7A));
            5: return 8'($urandom_range(8'h41, 8'h5A));
            6: return 8'($urandom_range(8'hC0, 8'hFF));
            7: return 8'($urandom_range(128, 165));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic offer_beat(input logic [2:0] k, input logic [7:0] c, input logic f);
        kind <= k;
        char_in <= c;
        first_of_string <= f;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(k, c, f);
        if (!calm && (sb.beats_in % 200) >= 40 && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14))
                @(posedge clk);
        end
    endtask

    task automatic send_string();
        int         len;
        bit         one_kind;
        logic [2:0] str_kind;
        logic [2:0] k;
        logic       f;
        len = $urandom_range(1, 12);
        one_kind = ($urandom_range(0, 4) != 0);
        str_kind = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(0, 4));
        for (int i = 0; i < len; i++)
        begin
            k = one_kind ? str_kind : 3'($urandom_range(0, 7));
            f = (i == 0) ? ($urandom_range(0, 19) != 0) : 1'b0;
            if ($urandom_range(0, 29) == 0)
                f = ~f;
            offer_beat(k, pick_char(), f);
        end
        strings_sent++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_output(char_out);
            if (!long_hold_done && sb.beats_in >= HOLD_AT_BEAT)
            begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!calm && (sb.beats_in % 250) >= 50 && $urandom_range(0, 9) == 0)
            begin
                hold_left = $urandom_range(1, 14) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("ERROR: no beat moved for %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            offer_beat(DIRECTED[i].kind, DIRECTED[i].ch, DIRECTED[i].first);

        while (sb.beats_in < RANDOM_BEATS + $size(DIRECTED))
        begin
            if (sb.beats_in >= RANDOM_BEATS + $size(DIRECTED) - CALM_TAIL)
                calm = 1'b1;
            send_string();
        end
        in_valid <= 1'b0;

        while (sb.expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Summary: %0d beats in %0d strings, %0d results checked, %0d mismatches",
                 sb.beats_in, strings_sent, sb.results_checked, sb.mismatches);
        $display("Beats per mode: up %0d, down %0d, plain %0d, words %0d, first %0d, spare %0d",
                 sb.beats_per_kind[0], sb.beats_per_kind[1], sb.beats_per_kind[2],
                 sb.beats_per_kind[3], sb.beats_per_kind[4],
                 sb.beats_per_kind[5] + sb.beats_per_kind[6] + sb.beats_per_kind[7]);
        if (sb.failures() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
design/mcct_pkg.sv
design/mcct_word_ctx.sv
design/mcct_char_map.sv
design/mixed_charset_case_transform.sv
verif/mixed_charset_case_transform_tb.sv
